>>> rtl/asa_pkg.sv
// ============================================================================
// asa_pkg: shared types and codes for the aligned stack allocator
// Holds the request and result word layouts, operation and status codes,
// and the sequencer state type.
// ============================================================================
`default_nettype none

package asa_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PAD_W  = 15;  // largest alignment mask is 2^15-1

  // operation codes
  localparam logic [1:0] FN_PUSH  = 2'd0;
  localparam logic [1:0] FN_POP   = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_NO_SLOT  = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE     = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef struct packed {
    logic [1:0]        func;
    logic [DATA_W-1:0] request_size;
    logic [3:0]        align_log2;
  } asa_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] address;
    logic [1:0]        status;
    logic [DATA_W-1:0] used_bytes;
    logic [5:0]        live_count;
  } asa_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_POP
  } asa_state_t;

endpackage : asa_pkg

`default_nettype wire

>>> rtl/asa_slot_ram.sv
// ============================================================================
// asa_slot_ram: saved fill level store
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module asa_slot_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned WORD_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : asa_slot_ram

`default_nettype wire

>>> rtl/aligned_stack_allocator.sv
// ============================================================================
// aligned_stack_allocator: LIFO allocator with power-of-two alignment
// Carves aligned blocks from a region [base, base+capacity), saves the
// previous fill level of each push in a slot memory and restores it on pop.
// ============================================================================
//
//  Channel   Ports                         Word / access
//  --------  ----------------------------  ---------------------------------
//  request   in_valid/in_ready/in_data     asa_req_t: func, size, alignment
//  result    out_valid/out_ready/out_data  asa_rsp_t: address, status, fill
//  config    cfg_p* (APB-style)            base at 0x0, capacity at 0x4
//
//  Steps: a request word is captured in an input register, then processed.
//  Push: aligned top and free room (S_IDLE), fit check and slot write
//  (S_PUSH). Pop: slot memory read (S_IDLE), restore (S_POP). Clear, no-op:
//  S_IDLE only. The next word is taken once this one's result is loaded.
//  Reset: fill level and live count clear at once; the slot memory holds
//  no reset value and needs no clearing pass, as pop only reads slots
//  written by earlier pushes.
//  Stalls: a new request word is captured while a result waits at the
//  output; processing holds until the output register frees up.
//
`default_nettype none

module aligned_stack_allocator #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire asa_pkg::asa_req_t in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output asa_pkg::asa_rsp_t      out_data,
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  import asa_pkg::*;

  // live count must hold MAX_SLOTS itself; slot index covers 0..MAX_SLOTS-1
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] cap_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? cap_r : base_r;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  asa_state_t        state_r, state_nxt;
  logic              req_vld_r, req_vld_nxt;
  asa_req_t          req_r, req_nxt;
  logic [DATA_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;     // base + fill, wraps
  logic [PAD_W-1:0]  pad_r, pad_nxt;     // bytes to reach the alignment
  logic [DATA_W-1:0] room_r, room_nxt;   // free bytes, zero when overfilled
  logic              out_vld_r, out_vld_nxt;
  asa_rsp_t          out_r, out_nxt;

  // slot memory port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // combinational helpers
  logic              out_free;
  logic              out_load;
  logic [DATA_W-1:0] top_sum;
  logic [PAD_W-1:0]  align_mask;
  logic [DATA_W:0]   need;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W+5:0]  live_ext;

  assign in_ready  = !req_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || out_ready;

  assign top_sum    = base_r + fill_r;
  assign align_mask = PAD_W'((16'h1 << req_r.align_log2) - 16'h1);
  assign need       = {1'b0, req_r.request_size} + (DATA_W + 1)'(pad_r);
  assign cnt_dec    = cnt_r - CNT_ONE;

  asa_slot_ram #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (IDX_W),
    .WORD_W (DATA_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (fill_r),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state, slot memory access and result word
  // --------------------------------------------------------------------------
  always_comb begin
    logic [DATA_W-1:0] res_addr;
    logic [1:0]        res_stat;

    state_nxt   = state_r;
    req_vld_nxt = req_vld_r;
    req_nxt     = req_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    pad_nxt     = pad_r;
    room_nxt    = room_r;
    out_vld_nxt = out_vld_r && !out_ready;
    out_nxt     = out_r;
    out_load    = 1'b0;
    res_addr    = '0;
    res_stat    = STAT_OK;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[IDX_W-1:0];
    mem_re      = 1'b0;
    mem_raddr   = cnt_dec[IDX_W-1:0];
    live_ext    = '0;

    // capture the next request word
    if (in_valid && in_ready) begin
      req_vld_nxt = 1'b1;
      req_nxt     = in_data;
    end

    case (state_r)
      S_IDLE: begin
        if (req_vld_r && out_free) begin
          case (req_r.func)
            FN_PUSH: begin
              // stage the aligned top and the free room for the fit check
              top_nxt   = top_sum;
              pad_nxt   = (~top_sum[PAD_W-1:0] + PAD_W'(1)) & align_mask;
              room_nxt  = (fill_r > cap_r) ? '0 : (cap_r - fill_r);
              state_nxt = S_PUSH;
            end
            FN_POP: begin
              if (cnt_r == '0) begin
                res_stat    = STAT_EMPTY;
                out_load    = 1'b1;
                req_vld_nxt = 1'b0;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_POP;
              end
            end
            FN_CLEAR: begin
              fill_nxt    = '0;
              cnt_nxt     = '0;
              out_load    = 1'b1;
              req_vld_nxt = 1'b0;
            end
            default: begin
              // no operation: report the state
              out_load    = 1'b1;
              req_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      S_PUSH: begin
        // space check wins over the slot check
        if (need > {1'b0, room_r}) begin
          res_stat = STAT_NO_SPACE;
        end else if (cnt_r >= MAX_CNT) begin
          res_stat = STAT_NO_SLOT;
        end else begin
          mem_we   = 1'b1;
          cnt_nxt  = cnt_r + CNT_ONE;
          fill_nxt = fill_r + need[DATA_W-1:0];
          res_addr = top_r + DATA_W'(pad_r);
        end
        out_load    = 1'b1;
        req_vld_nxt = 1'b0;
        state_nxt   = S_IDLE;
      end
      S_POP: begin
        // restore the saved level read last cycle
        fill_nxt    = mem_rdata;
        cnt_nxt     = cnt_dec;
        out_load    = 1'b1;
        req_vld_nxt = 1'b0;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      live_ext           = {6'b0, cnt_nxt};
      out_vld_nxt        = 1'b1;
      out_nxt.address    = res_addr;
      out_nxt.status     = res_stat;
      out_nxt.used_bytes = fill_nxt;
      out_nxt.live_count = live_ext[5:0];
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      fill_r    <= '0;
      cnt_r     <= '0;
      base_r    <= '0;
      cap_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      req_vld_r <= req_vld_nxt;
      out_vld_r <= out_vld_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_wr && (cfg_paddr[2] == REG_BASE)) begin
        base_r <= cfg_pwdata;
      end
      if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
        cap_r <= cfg_pwdata;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    top_r  <= top_nxt;
    pad_r  <= pad_nxt;
    room_r <= room_nxt;
    out_r  <= out_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("live count above slot count");

  a_wr_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cnt_r < MAX_CNT) && (state_r == S_PUSH))
    else $error("slot write without a free slot");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (cnt_r != '0) && $past(mem_re))
    else $error("pop restore without a slot read");

  a_fill_hold: assert property (@(posedge clk)
    rst_n && !out_load |=> $stable(fill_r) && $stable(cnt_r))
    else $error("allocator state moved without a result");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free && req_vld_r)
    else $error("result loaded over a pending result");

endmodule : aligned_stack_allocator

`default_nettype wire

>>> verif/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the aligned stack allocator
// Drives request words over a valid/ready channel and programs base and
// capacity through the APB-style port. Every result word is compared field
// by field with the in-bench allocator predictor or a hand-typed result. A
// directed table covers reset, extremes, address wrap, overfill, the empty
// and no-space codes. Random push/pop runs follow, random stalls both ways.
// ============================================================================

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asa_pkg::*;

  localparam int SLOTS       = 32;
  localparam int TOTAL_WORDS = 1040;    // about 1040 words in all, directed rows included
  localparam int CALM_AFTER  = 960;     // no idling on either side past this
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int HOLD_AFTER  = 200;     // results seen before the hold-off

  // One row of the directed plan: either a register write or a request word,
  // the latter optionally with its result typed in by hand.
  typedef struct packed {
    bit          is_reg;
    logic        reg_idx;
    logic [31:0] value;
    asa_req_t    word;
    bit          typed;
    asa_rsp_t    want;
  } row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  asa_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  asa_rsp_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state: register copies, fill level, live count, offset stack.
  logic [31:0] reg_base;
  logic [31:0] reg_cap;
  logic [31:0] fill_lvl;
  int unsigned live_n;
  logic [31:0] offset_stack [SLOTS];

  asa_rsp_t expected_rsp [$];

  int  mismatches;
  int  words_sent;
  int  results_seen;
  int  reg_writes;
  int  cycle_count;
  int  func_seen [4];
  int  stat_seen [4];
  bit  calm;

  aligned_stack_allocator #(.MAX_SLOTS(SLOTS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_rsp.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Allocator predictor. Advance the state by one request word and return
  // the result word it must produce. Sums are formed one bit wider so the
  // space check never wraps; addresses wrap modulo 2^32.
  // --------------------------------------------------------------------------
  function automatic asa_rsp_t predict_alloc(input asa_req_t w);
    asa_rsp_t    r;
    logic [31:0] mask;
    logic [31:0] top;
    logic [31:0] pad;
    logic [32:0] need;
    logic [32:0] room;
    r = '0;
    r.status = STAT_OK;
    case (w.func)
      FN_PUSH: begin
        mask = (32'd1 << w.align_log2) - 32'd1;
        top  = reg_base + fill_lvl;
        pad  = (32'd0 - top) & mask;
        need = {1'b0, w.request_size} + {1'b0, pad};
        // overfilled region (capacity lowered under live blocks) has no room
        room = (fill_lvl > reg_cap) ? 33'd0 : {1'b0, reg_cap - fill_lvl};
        if (need > room) begin
          r.status = STAT_NO_SPACE;   // checked before the slot limit
        end else if (live_n >= SLOTS) begin
          r.status = STAT_NO_SLOT;
        end else begin
          offset_stack[live_n] = fill_lvl;
          live_n++;
          r.address = top + pad;
          fill_lvl  = fill_lvl + need[31:0];
        end
      end
      FN_POP: begin
        if (live_n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          live_n--;
          fill_lvl = offset_stack[live_n];
        end
      end
      FN_CLEAR: begin
        live_n   = 0;
        fill_lvl = '0;
      end
      default: begin
        // no-op: just report the state
      end
    endcase
    r.used_bytes = fill_lvl;
    r.live_count = 6'(live_n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s got 0x%08h, expected 0x%08h",
             $time, results_seen, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result word with the oldest
  // expectation. Values are sampled at the edge, before any update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    asa_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      stat_seen[out_data.status]++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("result word with none expected", out_data.address, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (out_data.address !== want.address)
          report_mismatch("address", out_data.address, want.address);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.used_bytes !== want.used_bytes)
          report_mismatch("used_bytes", out_data.used_bytes, want.used_bytes);
        if (out_data.live_count !== want.live_count)
          report_mismatch("live_count", 32'(out_data.live_count),
                          32'(want.live_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready in random bursts, with stalls of random length. Once, hold
  // ready low for a long stretch while the sender keeps offering, so the
  // block backs up and drops in_ready. No stalls in the last part of the run.
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one word and hold it until accepted, then record the
  // expected result. Valid stays high into the next word unless a gap is
  // drawn; gaps have a random length.
  // --------------------------------------------------------------------------
  task automatic issue_word(input asa_req_t w, input bit typed,
                            input asa_rsp_t want);
    asa_rsp_t model_r;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    model_r = predict_alloc(w);
    expected_rsp.push_back(typed ? want : model_r);
    func_seen[w.func]++;
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Register write: drain all results first, let the pipeline settle,
  // then run the APB setup and access phases.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_BASE) reg_base = value;
    else                 reg_cap  = value;
    reg_writes++;
  endtask

  function automatic row_t word_row(input logic [1:0] f, input logic [31:0] sz,
                                    input logic [3:0] al);
    row_t r;
    r = '0;
    r.word.func         = f;
    r.word.request_size = sz;
    r.word.align_log2   = al;
    return r;
  endfunction

  function automatic row_t checked_row(input logic [1:0] f, input logic [31:0] sz,
                                       input logic [3:0] al,
                                       input logic [31:0] addr,
                                       input logic [1:0] st,
                                       input logic [31:0] used,
                                       input logic [5:0] live);
    row_t r;
    r = word_row(f, sz, al);
    r.typed           = 1'b1;
    r.want.address    = addr;
    r.want.status     = st;
    r.want.used_bytes = used;
    r.want.live_count = live;
    return r;
  endfunction

  function automatic row_t reg_row(input logic idx, input logic [31:0] value);
    row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.value   = value;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed plan, then random phases.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t        plan [$];
    asa_req_t    w;
    int          kind;
    int          n;
    int          phase;
    int          phase_end;
    logic [31:0] new_base;
    logic [31:0] new_cap;

    // drive every input known from time zero
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    reg_base = '0;
    reg_cap  = '0;
    fill_lvl = '0;
    live_n   = 0;
    calm     = 1'b0;

    // Directed plan. Registers start at zero: an empty region.
    // Pop on empty, zero-byte push into a zero-size region, overflow, no-op, clear.
    plan.push_back(checked_row(FN_POP,   32'd0, 4'd0, '0, STAT_EMPTY, '0, 6'd0));
    plan.push_back(checked_row(FN_PUSH,  32'd0, 4'd0, '0, STAT_OK, '0, 6'd1));
    plan.push_back(checked_row(FN_PUSH,  32'd1, 4'd0, '0, STAT_NO_SPACE, '0, 6'd1));
    plan.push_back(checked_row(FN_NOP,   32'hFFFF_FFFF, 4'd15, '0, STAT_OK, '0, 6'd1));
    plan.push_back(checked_row(FN_CLEAR, 32'hFFFF_FFFF, 4'd15, '0, STAT_OK, '0, 6'd0));
    // Base just below the top of the address space, full-size capacity:
    // aligned addresses wrap through zero.
    plan.push_back(reg_row(REG_BASE,     32'hFFFF_FFF0));
    plan.push_back(reg_row(REG_CAPACITY, 32'hFFFF_FFFF));
    plan.push_back(word_row(FN_PUSH, 32'd5,          4'd0));
    plan.push_back(word_row(FN_PUSH, 32'h100,        4'd15));
    plan.push_back(word_row(FN_PUSH, 32'hFFFF_FFFF,  4'd4));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(checked_row(FN_POP, 32'd0, 4'd0, '0, STAT_EMPTY, '0, 6'd0));
    // exact fit of the whole region, then padding alone does not fit
    plan.push_back(word_row(FN_PUSH, 32'hFFFF_FFFF,  4'd0));
    plan.push_back(word_row(FN_PUSH, 32'd0,          4'd15));
    plan.push_back(word_row(FN_PUSH, 32'd0,          4'd0));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(checked_row(FN_CLEAR, 32'd0, 4'd0, '0, STAT_OK, '0, 6'd0));
    // Live blocks, then shrink the region under them and move the base.
    plan.push_back(reg_row(REG_BASE,     32'h0));
    plan.push_back(reg_row(REG_CAPACITY, 32'h1000));
    plan.push_back(word_row(FN_PUSH, 32'h300,        4'd8));
    plan.push_back(word_row(FN_PUSH, 32'h200,        4'd2));
    plan.push_back(reg_row(REG_CAPACITY, 32'h100));
    plan.push_back(reg_row(REG_BASE,     32'h8000_0007));
    plan.push_back(word_row(FN_PUSH, 32'd0,          4'd3));
    plan.push_back(word_row(FN_PUSH, 32'd0,          4'd0));
    plan.push_back(word_row(FN_PUSH, 32'd1,          4'd0));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(word_row(FN_POP,  32'd0,          4'd0));
    plan.push_back(word_row(FN_PUSH, 32'h100,        4'd0));
    plan.push_back(word_row(FN_CLEAR, 32'd0,         4'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        issue_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    // Random phases of about 100 words, each under a new register setting.
    // The first two pin the extremes; live blocks carry across phases.
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      case (phase)
        0: begin
          new_base = '0;
          new_cap  = 32'hFFFF_FFFF;
        end
        1: begin
          new_base = 32'hFFFF_FFFF;
          new_cap  = '0;
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       new_base = '0;
            1:       new_base = 32'hFFFF_FFFF;
            2:       new_base = $urandom & 32'hFFFF_F000;
            3:       new_base = 32'hFFFF_0000 | 32'($urandom_range(0, 16'hFFFF));
            default: new_base = $urandom;
          endcase
          case ($urandom_range(0, 4))
            0:       new_cap = '0;
            1:       new_cap = 32'hFFFF_FFFF;
            4:       new_cap = $urandom;
            default: new_cap = 32'($urandom_range(32'h200, 32'h20000));
          endcase
        end
      endcase
      write_reg(REG_BASE, new_base);
      write_reg(REG_CAPACITY, new_cap);
      phase++;

      phase_end = words_sent + 100;
      while (words_sent < phase_end && words_sent < TOTAL_WORDS) begin
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
          // Well-formed stack work: a run of small pushes, deep enough to
          // hit the slot limit, then unwind, sometimes past empty.
          n = $urandom_range(1, 36);
          repeat (n) begin
            w.func         = FN_PUSH;
            w.request_size = ($urandom_range(0, 7) == 0) ?
                             32'($urandom_range(0, 4096)) : 32'($urandom_range(0, 64));
            w.align_log2   = ($urandom_range(0, 7) == 0) ?
                             4'($urandom_range(0, 15)) : 4'($urandom_range(0, 6));
            issue_word(w, 1'b0, '0);
          end
          repeat ($urandom_range(0, n + 2)) begin
            w = '0;
            w.func = FN_POP;
            issue_word(w, 1'b0, '0);
          end
        end else if (kind <= 6) begin
          // noise: any operation, any field values
          repeat (8) begin
            w.func         = 2'($urandom_range(0, 3));
            w.request_size = $urandom;
            w.align_log2   = 4'($urandom_range(0, 15));
            issue_word(w, 1'b0, '0);
          end
        end else if (kind == 7) begin
          w.func         = FN_CLEAR;
          w.request_size = $urandom;
          w.align_log2   = 4'($urandom_range(0, 15));
          issue_word(w, 1'b0, '0);
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 8)) begin
            w.func         = FN_POP;
            w.request_size = $urandom;
            w.align_log2   = 4'($urandom_range(0, 15));
            issue_word(w, 1'b0, '0);
          end
        end else begin
          // edge sizes: zero, all ones, single powers of two; plus a no-op
          repeat (4) begin
            w.func = FN_PUSH;
            case ($urandom_range(0, 2))
              0:       w.request_size = '0;
              1:       w.request_size = 32'hFFFF_FFFF;
              default: w.request_size = 32'd1 << $urandom_range(0, 31);
            endcase
            w.align_log2 = 4'($urandom_range(0, 15));
            issue_word(w, 1'b0, '0);
          end
          w.func = FN_NOP;
          issue_word(w, 1'b0, '0);
        end
      end
    end

    // Drain: wait for every expected result, then keep the clock running so a
    // stray extra word would still be caught.
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d request words (push %0d, pop %0d, clear %0d, no-op %0d), %0d reg writes",
             words_sent, func_seen[FN_PUSH], func_seen[FN_POP], func_seen[FN_CLEAR],
             func_seen[FN_NOP], reg_writes);
    $display("Result mix: ok %0d, no space %0d, no slot %0d, empty stack %0d; %0d mismatches",
             stat_seen[STAT_OK], stat_seen[STAT_NO_SPACE], stat_seen[STAT_NO_SLOT],
             stat_seen[STAT_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
